// ===== sv/chw_pkg.sv =====
package chw_pkg;

   // port packing
   localparam int REQ_TDATA_W = 32;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int TIMEOUT_W   = 32;
   localparam int STATUS_W    = 9;

   // status flag bit positions
   localparam int FLAG_COMM  = 0;
   localparam int FLAG_CMD   = 1;
   localparam int FLAG_HB    = 2;
   localparam int FLAG_QS    = 3;
   localparam int FLAG_STALE = 4;
   localparam int FLAG_HOLD  = 5;
   localparam int FLAG_EN    = 6;
   localparam int FLAG_RUN   = 7;
   localparam int FLAG_DONE  = 8;

   typedef enum logic [3:0] {
      CMD_FEED_CMD    = 4'd0,
      CMD_FEED_HB     = 4'd1,
      CMD_CHECK_CMD   = 4'd2,
      CMD_CHECK_HB    = 4'd3,
      CMD_CLEAR       = 4'd4,
      CMD_RUN         = 4'd5,
      CMD_STOP        = 4'd6,
      CMD_TRAJ_ACTIVE = 4'd7,
      CMD_TRAJ_DONE   = 4'd8,
      CMD_HOLD        = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      ACT_HOLD        = 3'd0,
      ACT_QUICK_STOP  = 3'd1,
      ACT_AUTO        = 3'd2,
      ACT_TORQUE_ZERO = 3'd3,
      ACT_FAULT       = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      REASON_NONE = 2'd0,
      REASON_CMD  = 2'd1,
      REASON_HB   = 2'd2
   } reason_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CMD_TIMEOUT  = 3'd0,
      CSR_HB_TIMEOUT   = 3'd1,
      CSR_TIMEOUT_ACT  = 3'd2,
      CSR_CONTROL_MODE = 3'd3,
      CSR_MIT_MODE     = 3'd4
   } csr_index_type;

   localparam logic [2:0] TIMEOUT_ACT_RESET   = 3'd2;
   localparam logic [1:0] CONTROL_MODE_RESET  = 2'd3;
   localparam logic [1:0] MODE_TORQUE         = 2'd1;
   localparam logic [1:0] MODE_POSITION       = 2'd3;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] cmd_timeout;
      logic [TIMEOUT_W-1:0] hb_timeout;
      logic [2:0]           action_code;
      logic [1:0]           ctrl_mode;
      logic                 mit_mode;
   } cfg_type;

   typedef struct packed {
      logic                expired;
      logic                quick_stop;
      logic                torque_zero;
      reason_type          reason;
      logic [STATUS_W-1:0] flags;
   } latch_type;

   // first member sits in the top bits, so status flags land at bit 0
   typedef struct packed {
      logic                fault_request;
      reason_type          timeout_reason;
      logic                torque_zero_on;
      logic                quick_stop_on;
      logic                watchdog_expired;
      logic                zero_mit_gains;
      action_type          action_taken;
      logic                timed_out_now;
      logic [STATUS_W-1:0] status_flags;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   function automatic latch_type clear_latches(input latch_type st);
      latch_type r;
      r = st;
      r.expired     = 1'b0;
      r.quick_stop  = 1'b0;
      r.torque_zero = 1'b0;
      r.reason      = REASON_NONE;
      r.flags[FLAG_COMM]  = 1'b0;
      r.flags[FLAG_CMD]   = 1'b0;
      r.flags[FLAG_HB]    = 1'b0;
      r.flags[FLAG_QS]    = 1'b0;
      r.flags[FLAG_STALE] = 1'b0;
      return r;
   endfunction

endpackage

// ===== sv/command_heartbeat_watchdog.sv =====
// path: an accepted req item goes through the input register, then the result register, to its rsp item
// throughput: one item per cycle while rsp_tready is high; req_tready stays high while the result register drains
// each item's deadline add, expiry subtract and flag update are combinational between the two
// reset: synchronous, active high; clears deadlines, latches, flags and both valid bits,
// and loads the register defaults (timeouts 0, action auto, position control, mit mode off)
module command_heartbeat_watchdog #(
   parameter int TICK_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // input item channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [chw_pkg::REQ_TDATA_W-1:0] req_tdata,  // [31:0] now_ms
   input  logic [chw_pkg::REQ_TUSER_W-1:0] req_tuser,  // [3:0] cmd
   // result item channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [chw_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [8:0] status_flags,
                                                       // [9] timed_out_now,
                                                       // [12:10] action_taken,
                                                       // [13] zero_mit_gains,
                                                       // [14] watchdog_expired,
                                                       // [15] quick_stop_on,
                                                       // [16] torque_zero_on,
                                                       // [18:17] timeout_reason,
                                                       // [19] fault_request, [23:20] zero
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [chw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [chw_pkg::CSR_DATA_W-1:0]  csr_data
);

   chw_pkg::cfg_type cfg;

   // input register: holds one item until the step logic hands it on
   logic                   in_valid_ff;
   logic [3:0]             in_cmd_ff;
   logic [TICK_BITS-1:0]   in_now_ff;

   // watchdog state
   chw_pkg::latch_type     st_ff;
   chw_pkg::latch_type     st_in;
   logic [TICK_BITS-1:0]   cmd_deadline_ff;
   logic [TICK_BITS-1:0]   cmd_deadline_in;
   logic [TICK_BITS-1:0]   hb_deadline_ff;
   logic [TICK_BITS-1:0]   hb_deadline_in;

   // result register
   logic                   out_valid_ff;
   chw_pkg::result_type    out_ff;
   chw_pkg::result_type    out_in;

   logic                   advance;
   logic                   req_take;

   // the item in the input register moves on when the result register is free or draining
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(chw_pkg::RSP_TDATA_W - chw_pkg::RESULT_W){1'b0}}, out_ff};

   chw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   chw_step #(
      .TICK_BITS (TICK_BITS)
   ) u_step (
      .cfg               (cfg),
      .st                (st_ff),
      .cmd_deadline      (cmd_deadline_ff),
      .hb_deadline       (hb_deadline_ff),
      .cmd               (in_cmd_ff),
      .now               (in_now_ff),
      .st_next           (st_in),
      .cmd_deadline_next (cmd_deadline_in),
      .hb_deadline_next  (hb_deadline_in),
      .res               (out_in)
   );

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         st_ff           <= '0;
         cmd_deadline_ff <= '0;
         hb_deadline_ff  <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         // state moves exactly once per item, when its result is captured
         if (in_valid_ff && advance) begin
            st_ff           <= st_in;
            cmd_deadline_ff <= cmd_deadline_in;
            hb_deadline_ff  <= hb_deadline_in;
         end
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff <= req_tuser[3:0];
         in_now_ff <= req_tdata[TICK_BITS-1:0];
      end
      if (in_valid_ff && advance) begin
         out_ff <= out_in;
      end
   end

endmodule

// ===== sv/chw_csr.sv =====
module chw_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [chw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [chw_pkg::CSR_DATA_W-1:0]  csr_data,
   output chw_pkg::cfg_type                cfg
);

   chw_pkg::cfg_type cfg_ff;
   chw_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            chw_pkg::CSR_CMD_TIMEOUT:  cfg_in.cmd_timeout = csr_data;
            chw_pkg::CSR_HB_TIMEOUT:   cfg_in.hb_timeout  = csr_data;
            chw_pkg::CSR_TIMEOUT_ACT:  cfg_in.action_code = csr_data[2:0];
            chw_pkg::CSR_CONTROL_MODE: cfg_in.ctrl_mode   = csr_data[1:0];
            chw_pkg::CSR_MIT_MODE:     cfg_in.mit_mode    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cmd_timeout <= '0;
         cfg_ff.hb_timeout  <= '0;
         cfg_ff.action_code <= chw_pkg::TIMEOUT_ACT_RESET;
         cfg_ff.ctrl_mode   <= chw_pkg::CONTROL_MODE_RESET;
         cfg_ff.mit_mode    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/chw_step.sv =====
module chw_step #(
   parameter int TICK_BITS = 32
) (
   input  chw_pkg::cfg_type           cfg,
   input  chw_pkg::latch_type         st,
   input  logic [TICK_BITS-1:0]       cmd_deadline,
   input  logic [TICK_BITS-1:0]       hb_deadline,
   input  logic [3:0]                 cmd,
   input  logic [TICK_BITS-1:0]       now,
   output chw_pkg::latch_type         st_next,
   output logic [TICK_BITS-1:0]       cmd_deadline_next,
   output logic [TICK_BITS-1:0]       hb_deadline_next,
   output chw_pkg::result_type        res
);

   logic [chw_pkg::TIMEOUT_W-1:0] timeout_sel;
   logic [TICK_BITS-1:0]          sum;
   logic [TICK_BITS-1:0]          dl_sel;
   logic [TICK_BITS-1:0]          diff;
   logic                          due;
   chw_pkg::action_type           act;
   chw_pkg::reason_type           why;

   // one adder for both feeds, one subtractor for both checks
   assign timeout_sel = (cmd == chw_pkg::CMD_FEED_HB) ? cfg.hb_timeout : cfg.cmd_timeout;
   assign sum         = now + timeout_sel[TICK_BITS-1:0];
   assign dl_sel      = (cmd == chw_pkg::CMD_CHECK_HB) ? hb_deadline : cmd_deadline;
   assign diff        = now - dl_sel;
   assign due         = (dl_sel != '0) && !st.expired && !diff[TICK_BITS-1];
   assign why         = (cmd == chw_pkg::CMD_CHECK_HB) ? chw_pkg::REASON_HB
                                                      : chw_pkg::REASON_CMD;

   // effective action
   always_comb begin
      if (cfg.action_code > chw_pkg::ACT_FAULT) begin
         act = chw_pkg::ACT_FAULT;
      end else if (cfg.action_code != chw_pkg::ACT_AUTO) begin
         act = chw_pkg::action_type'(cfg.action_code);
      end else if (cfg.mit_mode || cfg.ctrl_mode == chw_pkg::MODE_TORQUE) begin
         act = chw_pkg::ACT_TORQUE_ZERO;
      end else if (cfg.ctrl_mode == chw_pkg::MODE_POSITION) begin
         act = chw_pkg::ACT_HOLD;
      end else begin
         act = chw_pkg::ACT_AUTO;
      end
   end

   always_comb begin
      st_next           = st;
      cmd_deadline_next = cmd_deadline;
      hb_deadline_next  = hb_deadline;
      res               = '0;
      case (cmd)
         chw_pkg::CMD_FEED_CMD: begin
            if (cfg.cmd_timeout != '0) begin
               cmd_deadline_next = sum;
               if (st.expired || st.quick_stop || st.torque_zero) begin
                  st_next = chw_pkg::clear_latches(st);
               end
            end else begin
               cmd_deadline_next = '0;
            end
         end
         chw_pkg::CMD_FEED_HB: begin
            hb_deadline_next = (cfg.hb_timeout != '0) ? sum : '0;
         end
         chw_pkg::CMD_CHECK_CMD, chw_pkg::CMD_CHECK_HB: begin
            if (due) begin
               res.timed_out_now = 1'b1;
               res.action_taken  = act;
               st_next.expired   = 1'b1;
               st_next.reason    = why;
               st_next.flags[chw_pkg::FLAG_COMM] = 1'b1;
               if (why == chw_pkg::REASON_HB) begin
                  st_next.flags[chw_pkg::FLAG_HB] = 1'b1;
               end else begin
                  st_next.flags[chw_pkg::FLAG_CMD] = 1'b1;
               end
               if (cfg.mit_mode) begin
                  res.zero_mit_gains = 1'b1;
                  st_next.flags[chw_pkg::FLAG_STALE] = 1'b1;
               end
               case (act)
                  chw_pkg::ACT_HOLD: st_next.flags[chw_pkg::FLAG_HOLD] = 1'b1;
                  chw_pkg::ACT_QUICK_STOP, chw_pkg::ACT_AUTO: begin
                     st_next.quick_stop = 1'b1;
                     st_next.flags[chw_pkg::FLAG_QS] = 1'b1;
                  end
                  chw_pkg::ACT_TORQUE_ZERO: st_next.torque_zero = 1'b1;
                  default: res.fault_request = 1'b1;
               endcase
            end
         end
         chw_pkg::CMD_CLEAR: st_next = chw_pkg::clear_latches(st);
         chw_pkg::CMD_RUN: begin
            st_next.flags[chw_pkg::FLAG_EN]  = 1'b1;
            st_next.flags[chw_pkg::FLAG_RUN] = 1'b1;
         end
         chw_pkg::CMD_STOP: begin
            st_next.flags[chw_pkg::FLAG_EN]  = 1'b0;
            st_next.flags[chw_pkg::FLAG_RUN] = 1'b0;
         end
         chw_pkg::CMD_TRAJ_ACTIVE: begin
            st_next.flags[chw_pkg::FLAG_DONE] = 1'b0;
            st_next.flags[chw_pkg::FLAG_HOLD] = 1'b0;
         end
         chw_pkg::CMD_TRAJ_DONE: begin
            st_next.flags[chw_pkg::FLAG_DONE] = 1'b1;
            st_next.flags[chw_pkg::FLAG_HOLD] = 1'b1;
         end
         chw_pkg::CMD_HOLD: st_next.flags[chw_pkg::FLAG_HOLD] = 1'b1;
         default: ;
      endcase
      res.status_flags     = st_next.flags;
      res.watchdog_expired = st_next.expired;
      res.quick_stop_on    = st_next.quick_stop;
      res.torque_zero_on   = st_next.torque_zero;
      res.timeout_reason   = st_next.reason;
   end

endmodule
